@@ hdl/imd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imd_pkg
// Shared types and constants for the insulation monitor pwm status decoder.
// ----------------------------------------------------------------------------
package imd_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int CFG_ADDR_W      = 4;
    localparam int CFG_DATA_W      = 32;

    localparam logic [1:0] REG_CLOCK_FREQ     = 2'd0;
    localparam logic [1:0] REG_CAPTURE_ENABLE = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_MS     = 2'd2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd250;

    localparam logic       REQ_CAPTURE = 1'b0;
    localparam logic       REQ_READ    = 1'b1;

    localparam logic [2:0] STATUS_NORMAL  = 3'd1;
    localparam logic [2:0] STATUS_UNKNOWN = 3'd6;
    localparam int         STATUS_BANDS   = 6;

    localparam int BAND_STEP  = 10;
    localparam int BAND_HALF  = 5;
    localparam int DUTY_SCALE = 25600;
    localparam int FREQ_SHIFT = 4;

    localparam int BAND_QBITS = 3;
    localparam int DUTY_QBITS = 15;
    localparam int FREQ_QBITS = 10;
    localparam int CLK_NUM_W  = 32 + FREQ_SHIFT;

    localparam int DIV_Q_W    = 16;
    localparam int DIV_STEP_W = 5;

    typedef struct packed {
        logic        req_type;
        logic [31:0] high_ticks;
        logic [31:0] period_ticks;
        logic [31:0] now_ms;
        logic        sample_valid;
        logic        ok_hs;
    } in_word_t;

    typedef struct packed {
        logic        fault;
        logic [2:0]  status;
        logic [14:0] duty_q8;
        logic [9:0]  frequency_q4;
        logic        ok_hs_out;
        logic        is_ok;
    } out_word_t;

    typedef struct packed {
        logic                  load;
        logic [DIV_STEP_W-1:0] steps;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

@@ hdl/imd_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imd_div
// Shared restoring divider: one compare and subtract per cycle, divisor
// loaded pre-shifted to the top quotient bit and shifted right each step.
// ----------------------------------------------------------------------------
module imd_div
    import imd_pkg::*;
#(
    parameter int DIV_W = 47
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire div_ctrl_t        ctrl,
    input  wire logic [DIV_W-1:0] num,
    input  wire logic [DIV_W-1:0] den,
    output div_stat_t             stat,
    output logic [DIV_Q_W-1:0]    quot
);

    logic [DIV_W-1:0]      rem_reg;
    logic [DIV_W-1:0]      rem_next;
    logic [DIV_W-1:0]      den_reg;
    logic [DIV_W-1:0]      den_next;
    logic [DIV_Q_W-1:0]    quot_reg;
    logic [DIV_Q_W-1:0]    quot_next;
    logic [DIV_STEP_W-1:0] cnt_reg;
    logic [DIV_STEP_W-1:0] cnt_next;
    logic                  run_reg;
    logic                  run_next;
    logic                  ge;
    logic                  done;

    assign ge   = (rem_reg >= den_reg);
    assign done = run_reg && (cnt_reg == '0);

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        if (ctrl.load)
        begin
            rem_next  = num;
            den_next  = den;
            quot_next = '0;
            cnt_next  = ctrl.steps;
            run_next  = 1'b1;
        end
        else if (run_reg && (cnt_reg != '0))
        begin
            // one quotient bit per cycle
            if (ge)
            begin
                rem_next = rem_reg - den_reg;
            end
            den_next  = den_reg >> 1;
            quot_next = {quot_reg[DIV_Q_W-2:0], ge};
            cnt_next  = cnt_reg - DIV_STEP_W'(1);
        end
        else if (done)
        begin
            run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            quot_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            quot_reg <= quot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign stat.busy = run_reg && !done;
    assign stat.done = done;
    assign quot      = quot_reg;

endmodule
`default_nettype wire

@@ hdl/imd_pwm_status_decoder.sv @@
// capture words: taken while idle, stored while capture is enabled, no result
// read words: when all checks pass, band, duty and frequency go in turn through the
//   shared divider (band 4 steps, duty 16 steps, frequency 11 steps); when an
//   early check fails, the fault word is emitted without the divider
// input stalls while a read is in work; output is a register
// reset: clock_freq 0, capture disabled, timeout 250 ms, no capture seen
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imd_pwm_status_decoder
// Decodes the pwm status line of an insulation monitor from captured counts
// into status band, duty and frequency, failing closed on stale or bad data.
// ----------------------------------------------------------------------------
module imd_pwm_status_decoder
    import imd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_word_t              in_word,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_word_t                  out_word,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int DUTY_NUM_W = COUNT_WIDTH + DUTY_QBITS;
    localparam int DIV_W      = (DUTY_NUM_W > CLK_NUM_W) ? DUTY_NUM_W : CLK_NUM_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_BAND = 5'b00010,
        S_DUTY = 5'b00100,
        S_FREQ = 5'b01000,
        S_EMIT = 5'b10000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;

    logic [31:0]            clock_freq_reg;
    logic                   capture_enable_reg;
    logic [15:0]            timeout_ms_reg;

    logic                   seen_reg;
    logic [COUNT_WIDTH-1:0] stored_high_reg;
    logic [COUNT_WIDTH-1:0] stored_period_reg;
    logic [31:0]            stored_tick_reg;

    logic                   res_fault_reg;
    logic                   res_fault_next;
    logic [2:0]             res_band_reg;
    logic [2:0]             res_band_next;
    logic [14:0]            res_duty_reg;
    logic [14:0]            res_duty_next;
    logic                   res_okhs_reg;
    logic                   res_okhs_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    out_word_t              out_word_reg;
    out_word_t              out_word_next;

    logic                   cfg_write;
    logic                   in_take;
    logic                   out_free;
    logic [31:0]            age;
    logic                   early_fault;

    div_ctrl_t              div_ctrl;
    div_stat_t              div_stat;
    logic [DIV_Q_W-1:0]     div_quot;
    logic [DIV_W-1:0]       div_num;
    logic [DIV_W-1:0]       div_den;
    logic [DIV_W-1:0]       per_x;
    logic [DIV_W-1:0]       hi_x;
    logic [DIV_W-1:0]       clk_x;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_freq_reg     <= '0;
            capture_enable_reg <= 1'b0;
            timeout_ms_reg     <= TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_CLOCK_FREQ:     clock_freq_reg     <= pwdata;
                REG_CAPTURE_ENABLE: capture_enable_reg <= pwdata[0];
                REG_TIMEOUT_MS:     timeout_ms_reg     <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_CLOCK_FREQ:     prdata = clock_freq_reg;
            REG_CAPTURE_ENABLE: prdata = {{(CFG_DATA_W-1){1'b0}}, capture_enable_reg};
            REG_TIMEOUT_MS:     prdata = {{(CFG_DATA_W-16){1'b0}}, timeout_ms_reg};
            default:            prdata = '0;
        endcase
    end

    // input side
    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign age = in_word.now_ms - stored_tick_reg;

    assign early_fault = !capture_enable_reg || (clock_freq_reg == '0) ||
                         !in_word.sample_valid || !seen_reg ||
                         (age > {16'b0, timeout_ms_reg}) ||
                         (stored_period_reg == '0) ||
                         (stored_high_reg > stored_period_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg          <= 1'b0;
            stored_high_reg   <= '0;
            stored_period_reg <= '0;
            stored_tick_reg   <= '0;
        end
        else if (in_take && (in_word.req_type == REQ_CAPTURE) && capture_enable_reg)
        begin
            seen_reg          <= 1'b1;
            stored_high_reg   <= in_word.high_ticks[COUNT_WIDTH-1:0];
            stored_period_reg <= in_word.period_ticks[COUNT_WIDTH-1:0];
            stored_tick_reg   <= in_word.now_ms;
        end
    end

    // divider operands
    assign per_x = DIV_W'(stored_period_reg);
    assign hi_x  = DIV_W'(stored_high_reg);
    assign clk_x = DIV_W'(clock_freq_reg);

    always_comb
    begin
        case (state_reg)
            S_IDLE:
            begin
                div_num = clk_x + per_x * DIV_W'(BAND_HALF);
                div_den = (per_x * DIV_W'(BAND_STEP)) << BAND_QBITS;
            end
            S_BAND:
            begin
                div_num = hi_x * DIV_W'(DUTY_SCALE);
                div_den = per_x << DUTY_QBITS;
            end
            default:
            begin
                div_num = clk_x << FREQ_SHIFT;
                div_den = per_x << FREQ_QBITS;
            end
        endcase
    end

    imd_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .num   (div_num),
        .den   (div_den),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        res_fault_next = res_fault_reg;
        res_band_next  = res_band_reg;
        res_duty_next  = res_duty_reg;
        res_okhs_next  = res_okhs_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        div_ctrl.load  = 1'b0;
        div_ctrl.steps = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take && (in_word.req_type == REQ_READ))
                begin
                    res_okhs_next = in_word.ok_hs;
                    if (early_fault)
                    begin
                        res_fault_next = 1'b1;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        res_fault_next = 1'b0;
                        div_ctrl.load  = 1'b1;
                        div_ctrl.steps = DIV_STEP_W'(BAND_QBITS + 1);
                        state_next     = S_BAND;
                    end
                end
            end
            S_BAND:
            begin
                if (div_stat.done)
                begin
                    if (div_quot >= DIV_Q_W'(STATUS_BANDS))
                    begin
                        res_fault_next = 1'b1;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        res_band_next  = div_quot[2:0];
                        div_ctrl.load  = 1'b1;
                        div_ctrl.steps = DIV_STEP_W'(DUTY_QBITS + 1);
                        state_next     = S_DUTY;
                    end
                end
            end
            S_DUTY:
            begin
                if (div_stat.done)
                begin
                    res_duty_next  = div_quot[14:0];
                    div_ctrl.load  = 1'b1;
                    div_ctrl.steps = DIV_STEP_W'(FREQ_QBITS + 1);
                    state_next     = S_FREQ;
                end
            end
            S_FREQ:
            begin
                if (div_stat.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (res_fault_reg)
                    begin
                        out_word_next.fault        = 1'b1;
                        out_word_next.status       = STATUS_UNKNOWN;
                        out_word_next.duty_q8      = '0;
                        out_word_next.frequency_q4 = '0;
                        out_word_next.ok_hs_out    = 1'b0;
                        out_word_next.is_ok        = 1'b0;
                    end
                    else
                    begin
                        out_word_next.fault        = 1'b0;
                        out_word_next.status       = res_band_reg;
                        out_word_next.duty_q8      = res_duty_reg;
                        out_word_next.frequency_q4 = div_quot[9:0];
                        out_word_next.ok_hs_out    = res_okhs_reg;
                        out_word_next.is_ok        = res_okhs_reg &&
                                                     (res_band_reg == STATUS_NORMAL);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_fault_reg <= res_fault_next;
        res_band_reg  <= res_band_next;
        res_duty_reg  <= res_duty_next;
        res_okhs_reg  <= res_okhs_next;
        out_word_reg  <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule
`default_nettype wire

@@ hdl/imd_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imd_chk
// Port-level checks on the pwm status decoder, bound to the top level.
// ----------------------------------------------------------------------------
module imd_chk
    import imd_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire in_word_t  in_word,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_word_t out_word
);

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    // fail-closed word is fully cleared
    a_fault_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.fault |->
            (out_word.status == STATUS_UNKNOWN) && (out_word.duty_q8 == '0) &&
            (out_word.frequency_q4 == '0) && !out_word.ok_hs_out && !out_word.is_ok)
        else $error("fault word not cleared");

    // good decode lies within the status bands
    a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.fault |-> (out_word.status < STATUS_UNKNOWN))
        else $error("status band out of range on good decode");

    a_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.is_ok |->
            !out_word.fault && out_word.ok_hs_out && (out_word.status == STATUS_NORMAL))
        else $error("is_ok without its conditions");

    // a read occupies the sequencer
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_word.req_type == REQ_READ) |=> in_stall)
        else $error("input taken again right after a read");

endmodule

bind imd_pwm_status_decoder imd_chk u_imd_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);
`default_nettype wire

@@ tb/tb_imd_pwm_status_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imd_pwm_status_decoder
// Self-checking bench for the insulation monitor pwm status decoder. Capture
// and read words go in through a queued driver; each accepted capture word
// loads a local copy of the capture state while capture is enabled, and each
// read predicts the status word it must produce. A monitor compares every
// status word field by field while both sides idle and stall at random.
// Settings change over the apb port between phases, once the decoder is quiet.
// ----------------------------------------------------------------------------
module tb_imd_pwm_status_decoder;
    import imd_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    in_word_t              in_word = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_word_t             out_word;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // local copy of settings and capture state
    logic [31:0] cfg_clock = '0;
    logic        cfg_enable = 1'b0;
    logic [15:0] cfg_timeout = TIMEOUT_RESET;
    logic        cap_seen = 1'b0;
    logic [31:0] cap_high = '0;
    logic [31:0] cap_period = '0;
    logic [31:0] cap_tick = '0;

    in_word_t    words_to_send[$];
    out_word_t   due_status[$];
    int unsigned mismatches = 0;
    int unsigned send_gap = 0;
    int unsigned recv_hold = 0;
    logic        send_idle = 1'b1;
    logic        recv_idle = 1'b1;

    imd_pwm_status_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // capture words load the state, read words queue the status they must give
    function automatic void predict_decode(input in_word_t w);
        out_word_t   r;
        logic [31:0] age;
        logic [63:0] per;
        logic [63:0] band;
        logic [63:0] duty;
        logic [63:0] freq;
        if (w.req_type == REQ_CAPTURE)
        begin
            if (cfg_enable)
            begin
                cap_high   = w.high_ticks;
                cap_period = w.period_ticks;
                cap_tick   = w.now_ms;
                cap_seen   = 1'b1;
            end
            return;
        end
        r        = '0;
        r.fault  = 1'b1;
        r.status = STATUS_UNKNOWN;
        age      = w.now_ms - cap_tick;
        per      = 64'(cap_period);
        if (cfg_enable && cfg_clock != 0 && w.sample_valid && cap_seen &&
            age <= 32'(cfg_timeout) && per != 0 && cap_high <= cap_period)
        begin
            band = (64'(cfg_clock) + 5 * per) / (10 * per);
            if (band < STATUS_BANDS)
            begin
                duty           = (64'(cap_high) * 25600) / per;
                freq           = (64'(cfg_clock) * 16) / per;
                r.fault        = 1'b0;
                r.status       = band[2:0];
                r.duty_q8      = duty[14:0];
                r.frequency_q4 = freq[9:0];
                r.ok_hs_out    = w.ok_hs;
                r.is_ok        = w.ok_hs && band[2:0] == STATUS_NORMAL;
            end
        end
        due_status.push_back(r);
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h got %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_decode(in_word);
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (words_to_send.size() > 0)
                begin
                    in_word  <= words_to_send.pop_front();
                    in_valid <= 1'b1;
                    if (send_idle && $urandom_range(0, 2) == 0)
                        send_gap <= gap_len();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin : monitor
        out_word_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_status.size() == 0)
                begin
                    $display("%0t: status word %h with none expected", $time, out_word);
                    mismatches++;
                end
                else
                begin
                    want = due_status.pop_front();
                    check_field("fault", want.fault, out_word.fault);
                    check_field("status", want.status, out_word.status);
                    check_field("duty_q8", want.duty_q8, out_word.duty_q8);
                    check_field("frequency_q4", want.frequency_q4, out_word.frequency_q4);
                    check_field("ok_hs_out", want.ok_hs_out, out_word.ok_hs_out);
                    check_field("is_ok", want.is_ok, out_word.is_ok);
                end
            end
            if (recv_hold > 0)
            begin
                recv_hold <= recv_hold - 1;
                out_stall <= 1'b1;
            end
            else if (recv_idle && $urandom_range(0, 3) == 0)
            begin
                recv_hold <= gap_len() - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CLOCK_FREQ:     cfg_clock = value;
            REG_CAPTURE_ENABLE: cfg_enable = value[0];
            REG_TIMEOUT_MS:     cfg_timeout = value[15:0];
            default: ;
        endcase
    endtask

    // all words taken, all status words back, then room for a capture in flight
    task automatic wait_quiet();
        while (words_to_send.size() != 0 || in_valid || due_status.size() != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
    endtask

    function automatic void push_word(input logic req, input logic [31:0] hi,
                                      input logic [31:0] per, input logic [31:0] now,
                                      input logic valid, input logic okhs);
        in_word_t w;
        w.req_type     = req;
        w.high_ticks   = hi;
        w.period_ticks = per;
        w.now_ms       = now;
        w.sample_valid = valid;
        w.ok_hs        = okhs;
        words_to_send.push_back(w);
    endfunction

    // period for a pwm frequency between 0.1 and 65 hz at the current clock
    function automatic logic [31:0] pick_period();
        logic [63:0] p;
        p = (64'(cfg_clock) * 10) / $urandom_range(1, 650);
        if ($urandom_range(0, 19) == 0)
            p = 64'($urandom);
        if (p == 0)
            p = 1;
        if (p > 64'hFFFF_FFFF)
            p = 64'hFFFF_FFFF;
        return p[31:0];
    endfunction

    task automatic run_phase(input int unsigned n);
        int unsigned  sent;
        int unsigned  r;
        int unsigned  k;
        int unsigned  reads;
        logic [31:0]  tick;
        logic [31:0]  per;
        logic [31:0]  hi;
        logic [31:0]  age;
        logic [63:0]  wide;
        logic [127:0] raw;
        sent = 0;
        tick = $urandom;
        @(negedge clk);
        while (sent < n)
        begin
            r    = $urandom_range(0, 99);
            tick = tick + $urandom_range(0, 40);
            if (r < 90)
            begin
                per  = pick_period();
                wide = 64'($urandom) % (64'(per) + 1);
                hi   = wide[31:0];
                k    = $urandom_range(0, 9);
                if (k == 0)
                    hi = per;
                else if (k == 1)
                    hi = '0;
                // broken capture: empty period or high past the period
                if (r >= 75)
                begin
                    if ($urandom_range(0, 1) == 0)
                        per = '0;
                    else if (per < 32'hFFFF_FF00)
                        hi = per + 1 + $urandom_range(0, 5);
                end
                push_word(REQ_CAPTURE, hi, per, tick, $urandom_range(0, 1),
                          $urandom_range(0, 1));
                reads = $urandom_range(1, 3);
                sent  = sent + 1 + reads;
                repeat (reads)
                begin
                    k = $urandom_range(0, 19);
                    if (k == 0)
                        age = 32'(cfg_timeout) + 1 + $urandom_range(0, 100);
                    else if (k == 1)
                        age = $urandom;
                    else if (k == 2)
                        age = 32'(cfg_timeout);
                    else
                        age = $urandom_range(0, cfg_timeout);
                    push_word(REQ_READ, $urandom, $urandom, tick + age,
                              $urandom_range(0, 15) != 0, $urandom_range(0, 1));
                end
            end
            else
            begin
                raw = {$urandom, $urandom, $urandom, $urandom};
                words_to_send.push_back(in_word_t'(raw[98:0]));
                sent++;
            end
        end
    endtask

    initial
    begin : stimulus
        logic [31:0] clk_hz;
        logic [31:0] to;
        logic        en;
        int unsigned n;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: capture off, clock zero
        @(negedge clk);
        push_word(REQ_READ, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1);
        push_word(REQ_CAPTURE, 32'd10, 32'd100, 32'd5, 1'b1, 1'b1);
        wait_quiet();
        cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
        cfg_write(REG_CLOCK_FREQ, 32'd1_000_000);
        cfg_write(REG_CAPTURE_ENABLE, 32'd1);

        @(negedge clk);
        push_word(REQ_READ, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1);
        push_word(REQ_CAPTURE, 32'd0, 32'd100000, 32'hFFFF_FFF0, 1'b0, 1'b0);
        push_word(REQ_READ, 32'd0, 32'd0, 32'hFFFF_FFF0 + 32'd250, 1'b1, 1'b1);
        push_word(REQ_READ, 32'd0, 32'd0, 32'hFFFF_FFF0 + 32'd251, 1'b1, 1'b1);
        push_word(REQ_READ, 32'd0, 32'd0, 32'hFFFF_FFFA, 1'b0, 1'b1);
        push_word(REQ_CAPTURE, 32'd100000, 32'd100000, 32'd1000, 1'b1, 1'b1);
        push_word(REQ_READ, 32'd0, 32'd0, 32'd1000, 1'b1, 1'b0);
        push_word(REQ_CAPTURE, 32'd0, 32'd0, 32'd1100, 1'b1, 1'b1);
        push_word(REQ_READ, 32'd0, 32'd0, 32'd1100, 1'b1, 1'b1);
        push_word(REQ_CAPTURE, 32'd50001, 32'd50000, 32'd1200, 1'b1, 1'b1);
        push_word(REQ_READ, 32'd0, 32'd0, 32'd1210, 1'b1, 1'b1);
        push_word(REQ_CAPTURE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1300, 1'b1, 1'b1);
        push_word(REQ_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1300, 1'b1, 1'b1);
        // band edge: 55 hz is the last band below unknown
        push_word(REQ_CAPTURE, 32'd9091, 32'd18182, 32'd1400, 1'b1, 1'b1);
        push_word(REQ_READ, 32'd0, 32'd0, 32'd1400, 1'b1, 1'b1);
        push_word(REQ_CAPTURE, 32'd0, 32'd18181, 32'd1500, 1'b1, 1'b1);
        push_word(REQ_READ, 32'd0, 32'd0, 32'd1500, 1'b1, 1'b1);
        push_word(REQ_CAPTURE, 32'd25000, 32'd50000, 32'd7000, 1'b1, 1'b1);
        push_word(REQ_READ, 32'd0, 32'd0, 32'd7000, 1'b1, 1'b1);

        // capture off keeps the stored capture for later
        wait_quiet();
        cfg_write(REG_CAPTURE_ENABLE, 32'd0);
        @(negedge clk);
        push_word(REQ_CAPTURE, 32'd1, 32'd2, 32'd7005, 1'b1, 1'b1);
        push_word(REQ_READ, 32'd0, 32'd0, 32'd7005, 1'b1, 1'b1);
        wait_quiet();
        cfg_write(REG_CAPTURE_ENABLE, 32'd1);
        cfg_write(REG_TIMEOUT_MS, 32'd250);
        @(negedge clk);
        push_word(REQ_READ, 32'd0, 32'd0, 32'd7010, 1'b1, 1'b1);

        for (int p = 0; p < 10; p++)
        begin
            wait_quiet();
            case (p)
                0: begin clk_hz = 32'd1_000_000; to = 32'd250; en = 1'b1; end
                1: begin clk_hz = 32'hFFFF_FFFF; to = 32'hFFFF; en = 1'b1; end
                2: begin clk_hz = 32'd1; to = 32'd0; en = 1'b1; end
                3: begin clk_hz = 32'd0; to = 32'd500; en = 1'b1; end
                4: begin clk_hz = $urandom; to = $urandom_range(0, 2000); en = 1'b0; end
                5: begin clk_hz = 32'd64_000_000; to = 32'd0; en = 1'b1; end
                default:
                begin
                    clk_hz = $urandom_range(1000, 100_000_000);
                    to     = $urandom_range(0, 65535);
                    en     = 1'b1;
                end
            endcase
            cfg_write(REG_CLOCK_FREQ, clk_hz);
            cfg_write(REG_TIMEOUT_MS, ($urandom & 32'hFFFF_0000) | to);
            cfg_write(REG_CAPTURE_ENABLE, ($urandom & 32'hFFFF_FFFE) | 32'(en));
            send_idle = (p % 3 != 0);
            recv_idle = (p % 4 != 1);
            n = (p == 3 || p == 4) ? 60 : 190;
            run_phase(n);
        end

        wait_quiet();
        if (mismatches == 0)
            $display("tb_imd_pwm_status_decoder: clean");
        else
            $display("tb_imd_pwm_status_decoder: errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb_imd_pwm_status_decoder: errors");
        $finish;
    end

endmodule
